FILE: src/ecg_pkg.sv
package ecg_pkg;

   // number formats: progress and result use 16 fraction bits, the datapath uses 30
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 17;
   localparam int WBITS     = 30;
   localparam int QW        = WBITS + 1;
   localparam int EW        = 32;

   typedef logic [QW-1:0]   q_type;
   typedef logic [EW-1:0]   exp_type;
   typedef logic [2:0]      mode_type;
   typedef logic [IN_W-1:0] io_type;

   localparam q_type  W_ONE  = q_type'(1) << WBITS;
   localparam io_type IN_ONE = io_type'(1) << FRAC_BITS;

   // curve select codes, anything else is linear
   localparam mode_type MODE_COS_IN   = 3'd1;
   localparam mode_type MODE_COS_OUT  = 3'd2;
   localparam mode_type MODE_RUBBER   = 3'd3;
   localparam mode_type MODE_BOUNCE   = 3'd4;
   localparam mode_type MODE_SCURVE   = 3'd5;
   localparam mode_type MODE_LOGISTIC = 3'd6;

   // pipeline sizes
   localparam int SQRT_LAT  = WBITS + 1;
   localparam int COS_STEPS = 7;
   localparam int EXP_STEPS = 10;
   localparam int DIV_BITS  = 30;
   localparam int PIPE_LAST = 65;

   // cos(pi/2 u) as even polynomial in u*u
   localparam q_type COS_COEF [COS_STEPS+1] = '{
      31'd1073741824, 31'd1324675879, 31'd272375560, 31'd22401992,
      31'd987048, 31'd27061, 31'd506, 31'd7
   };

   // 2^r on [0,1)
   localparam exp_type EXP2_COEF [EXP_STEPS+1] = '{
      32'd1073741824, 32'd744261118, 32'd257941248, 32'd59597083, 32'd10327388,
      32'd1431680, 32'd165394, 32'd16378, 32'd1419, 32'd109, 32'd8
   };

   // floor(2^37 / 127), reciprocal for the 128/127 scale
   localparam q_type DIV127_MUL = 31'd1082196484;

endpackage

FILE: src/ecg_sqrt.sv
module ecg_sqrt (
   input  logic          clock,
   input  logic          adv,
   input  ecg_pkg::q_type radicand,
   output ecg_pkg::q_type root
);

   localparam int STEPS = ecg_pkg::SQRT_LAT;
   localparam int XW    = 2 * ecg_pkg::WBITS + 1;
   localparam int RW    = 2 * ecg_pkg::WBITS + 2;

   logic [XW-1:0] x_ff [STEPS];
   logic [XW-1:0] x_in [STEPS];
   logic [RW-1:0] r_ff [STEPS];
   logic [RW-1:0] r_in [STEPS];

   // one root bit per stage, radicand scaled by 2^30
   always_comb begin
      logic [XW-1:0] xs;
      logic [RW-1:0] rs;
      logic [RW-1:0] bit_v;
      logic [RW-1:0] trial;
      for (int i = 0; i < STEPS; i++) begin
         if (i == 0) begin
            xs = {radicand, {ecg_pkg::WBITS{1'b0}}};
            rs = '0;
         end else begin
            xs = x_ff[i-1];
            rs = r_ff[i-1];
         end
         bit_v = RW'(1) << (2 * (STEPS - 1 - i));
         trial = rs + bit_v;
         if ({1'b0, xs} >= trial) begin
            x_in[i] = xs - trial[XW-1:0];
            r_in[i] = (rs >> 1) + bit_v;
         end else begin
            x_in[i] = xs;
            r_in[i] = rs >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         r_ff <= r_in;
      end
   end

   assign root = r_ff[STEPS-1][ecg_pkg::QW-1:0];

endmodule

FILE: src/ecg_cos.sv
module ecg_cos (
   input  logic          clock,
   input  logic          adv,
   input  ecg_pkg::q_type arg,
   output ecg_pkg::q_type cos_val
);

   localparam int STEPS = ecg_pkg::COS_STEPS;
   localparam int PW    = 2 * ecg_pkg::QW;
   localparam int YD    = 2 * STEPS - 1;

   ecg_pkg::q_type y_in;
   ecg_pkg::q_type ydl_ff [YD];
   ecg_pkg::q_type prod_ff [STEPS];
   ecg_pkg::q_type prod_in [STEPS];
   ecg_pkg::q_type p_ff [STEPS];
   ecg_pkg::q_type p_in [STEPS];

   // square of the argument
   always_comb begin
      logic [PW-1:0] sq;
      sq   = PW'(arg) * PW'(arg);
      y_in = sq[ecg_pkg::WBITS +: ecg_pkg::QW];
   end

   // horner steps: multiply stage, then clamped subtract stage
   always_comb begin
      ecg_pkg::q_type pv;
      ecg_pkg::q_type coef;
      logic [PW-1:0]  mul;
      for (int j = 0; j < STEPS; j++) begin
         pv         = (j == 0) ? ecg_pkg::COS_COEF[STEPS] : p_ff[(j == 0) ? 0 : j - 1];
         mul        = PW'(pv) * PW'(ydl_ff[2*j]);
         prod_in[j] = mul[ecg_pkg::WBITS +: ecg_pkg::QW];
         coef       = (j < STEPS - 1) ? ecg_pkg::COS_COEF[STEPS-1-j] : ecg_pkg::W_ONE;
         p_in[j]    = (prod_ff[j] >= coef) ? '0 : coef - prod_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ydl_ff[0] <= y_in;
         for (int i = 1; i < YD; i++) begin
            ydl_ff[i] <= ydl_ff[i-1];
         end
         prod_ff <= prod_in;
         p_ff    <= p_in;
      end
   end

   assign cos_val = p_ff[STEPS-1];

endmodule

FILE: src/ecg_logistic.sv
module ecg_logistic (
   input  logic          clock,
   input  logic          adv,
   input  ecg_pkg::q_type t_val,
   output ecg_pkg::q_type curve_val
);

   localparam int WB    = ecg_pkg::WBITS;
   localparam int QW    = ecg_pkg::QW;
   localparam int EW    = ecg_pkg::EW;
   localparam int NS    = ecg_pkg::EXP_STEPS;
   localparam int DB    = ecg_pkg::DIV_BITS;
   localparam int XW    = WB + 4;
   localparam int DW    = WB + 11;
   localparam int RD    = 2 * NS - 1;
   localparam int ND    = 2 * NS + 1;
   localparam int HD    = 2 * NS + DB + 2;
   localparam logic [XW-1:0] EIGHT_W = XW'(ecg_pkg::W_ONE) << 3;
   localparam ecg_pkg::q_type HALF    = ecg_pkg::W_ONE >> 1;
   localparam ecg_pkg::q_type LOW_CUT = ecg_pkg::W_ONE >> 8;
   localparam logic [DW-1:0] REM_INIT = DW'(ecg_pkg::W_ONE);

   // exponent split
   logic [3:0]    n_in;
   logic [WB-1:0] r_in;
   logic          hi_in;
   logic [WB-1:0] rdl_ff [RD];
   logic [3:0]    ndl_ff [ND];
   logic          hidl_ff [HD];

   // horner for 2^r
   ecg_pkg::exp_type prod_ff [NS];
   ecg_pkg::exp_type prod_in [NS];
   ecg_pkg::exp_type p_ff [NS];
   ecg_pkg::exp_type p_in [NS];

   // divider
   logic [DW-1:0] d_ff;
   logic [DW-1:0] rem_ff [DB];
   logic [DW-1:0] rem_in [DB];
   logic [DW-1:0] dd_ff [DB];
   logic [DW-1:0] dd_in [DB];
   logic [DB-1:0] quo_ff [DB];
   logic [DB-1:0] quo_in [DB];

   // offset and 128/127 scale
   logic [WB-1:0] y_ff;
   logic          zero_ff;
   logic [WB-1:0] y_in;
   logic          zero_in;
   logic [23:0]   qe_ff;
   logic [23:0]   qe_in;
   logic [WB-1:0] y2_ff;
   logic          zero2_ff;
   logic [7:0]    rr_ff;
   logic [7:0]    rr_in;
   logic [WB-1:0] y3_ff;
   logic [23:0]   qe3_ff;
   logic          zero3_ff;
   ecg_pkg::q_type out_ff;
   ecg_pkg::q_type out_in;

   // x = |8 - 16t| and which half of the curve
   always_comb begin
      logic [XW:0]   t16;
      logic [XW-1:0] x;
      t16   = {t_val, 4'b0000};
      hi_in = (t_val > HALF);
      if (hi_in) begin
         x = t16[XW-1:0] - EIGHT_W;
      end else begin
         x = EIGHT_W - t16[XW-1:0];
      end
      n_in = x[XW-1:WB];
      r_in = x[WB-1:0];
   end

   always_comb begin
      ecg_pkg::exp_type pv;
      logic [EW+WB-1:0] mul;
      for (int j = 0; j < NS; j++) begin
         pv         = (j == 0) ? ecg_pkg::EXP2_COEF[NS] : p_ff[(j == 0) ? 0 : j - 1];
         mul        = (EW+WB)'(pv) * (EW+WB)'(rdl_ff[2*j]);
         prod_in[j] = mul[WB +: EW];
         p_in[j]    = ecg_pkg::EXP2_COEF[NS-1-j] + prod_ff[j];
      end
   end

   // restoring divide of 2^60 by 2^30 (1 + 2^x), one quotient bit per stage
   always_comb begin
      logic [DW-1:0] rs;
      logic [DW-1:0] ds;
      logic [DB-1:0] qs;
      logic [DW:0]   r2;
      for (int i = 0; i < DB; i++) begin
         if (i == 0) begin
            rs = REM_INIT;
            ds = d_ff;
            qs = '0;
         end else begin
            rs = rem_ff[i-1];
            ds = dd_ff[i-1];
            qs = quo_ff[i-1];
         end
         r2 = {rs, 1'b0};
         if (r2 >= {1'b0, ds}) begin
            rem_in[i] = DW'(r2 - {1'b0, ds});
            quo_in[i] = qs | (DB'(1) << (DB - 1 - i));
         end else begin
            rem_in[i] = r2[DW-1:0];
            quo_in[i] = qs;
         end
         dd_in[i] = ds;
      end
   end

   // mirror, subtract 1/256, then y + y/127
   always_comb begin
      ecg_pkg::q_type f;
      logic [QW-1:0]  quo;
      logic [60:0]    mul;
      logic [QW-1:0]  rr;
      quo     = QW'(quo_ff[DB-1]);
      f       = hidl_ff[HD-1] ? ecg_pkg::W_ONE - quo : quo;
      zero_in = (f <= LOW_CUT);
      y_in    = WB'(f - LOW_CUT);
      mul     = 61'(y_ff) * 61'(ecg_pkg::DIV127_MUL);
      qe_in   = mul[60:37];
      rr      = QW'(y2_ff) - ((QW'(qe_ff) << 7) - QW'(qe_ff));
      rr_in   = rr[7:0];
      out_in  = zero3_ff ? '0 : QW'(y3_ff) + QW'(qe3_ff) + QW'(rr_ff >= 8'd127);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rdl_ff[0]  <= r_in;
         ndl_ff[0]  <= n_in;
         hidl_ff[0] <= hi_in;
         for (int i = 1; i < RD; i++) begin
            rdl_ff[i] <= rdl_ff[i-1];
         end
         for (int i = 1; i < ND; i++) begin
            ndl_ff[i] <= ndl_ff[i-1];
         end
         for (int i = 1; i < HD; i++) begin
            hidl_ff[i] <= hidl_ff[i-1];
         end
         prod_ff  <= prod_in;
         p_ff     <= p_in;
         d_ff     <= DW'(ecg_pkg::W_ONE) + (DW'(p_ff[NS-1]) << ndl_ff[ND-1]);
         rem_ff   <= rem_in;
         dd_ff    <= dd_in;
         quo_ff   <= quo_in;
         y_ff     <= y_in;
         zero_ff  <= zero_in;
         qe_ff    <= qe_in;
         y2_ff    <= y_ff;
         zero2_ff <= zero_ff;
         rr_ff    <= rr_in;
         y3_ff    <= y2_ff;
         qe3_ff   <= qe_ff;
         zero3_ff <= zero2_ff;
         out_ff   <= out_in;
      end
   end

   assign curve_val = out_ff;

endmodule

FILE: src/easing_curve_generator.sv
// a taken req beat runs down the result chain val_ff and the output register to rsp_valid
// throughput: one beat per cycle; a stalled rsp beat freezes the whole pipeline
// the mode in force when a beat is taken travels with it down the pipeline
// synchronous reset clears all valid bits and sets the mode to linear (0)
module easing_curve_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ecg_pkg::io_type      req_progress,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ecg_pkg::io_type      rsp_eased_value,
   input  logic                 csr_wr_en,
   input  ecg_pkg::mode_type    csr_wr_data
);

   localparam int LAST = ecg_pkg::PIPE_LAST;
   localparam int QW   = ecg_pkg::QW;
   localparam int WB   = ecg_pkg::WBITS;
   localparam int PW   = 2 * QW;
   localparam int CD   = 15;
   localparam int MD   = 31;
   localparam ecg_pkg::q_type W    = ecg_pkg::W_ONE;
   localparam ecg_pkg::q_type HALF = ecg_pkg::W_ONE >> 1;
   localparam logic [33:0] SEG_A = 34'(ecg_pkg::W_ONE) << 2;
   localparam logic [33:0] SEG_B = 34'(ecg_pkg::W_ONE) << 3;
   localparam logic [33:0] SEG_C = 34'(ecg_pkg::W_ONE) * 10;
   localparam logic [33:0] MID_A = 34'(ecg_pkg::W_ONE) * 6;
   localparam logic [33:0] MID_B = 34'(ecg_pkg::W_ONE) * 9;
   localparam logic [33:0] MID_C = 34'(ecg_pkg::W_ONE) * 10 + (34'(ecg_pkg::W_ONE) >> 1);
   localparam ecg_pkg::q_type LIFT_A = (ecg_pkg::W_ONE * 3) >> 2;
   localparam ecg_pkg::q_type LIFT_B = ecg_pkg::W_ONE - (ecg_pkg::W_ONE >> 4);
   localparam ecg_pkg::q_type LIFT_C = ecg_pkg::W_ONE - (ecg_pkg::W_ONE >> 6);
   localparam logic [QW:0] ROUND_HALF = (QW+1)'(1) << (WB - ecg_pkg::FRAC_BITS - 1);

   logic adv;

   // control and result chain
   ecg_pkg::mode_type csr_mode_ff;
   ecg_pkg::q_type    val_ff [LAST+1];
   ecg_pkg::q_type    val_in [LAST+1];
   ecg_pkg::mode_type mode_ff [LAST+1];
   ecg_pkg::mode_type mode_in [LAST+1];
   logic              vld_ff [LAST+1];
   logic              vld_in [LAST+1];

   // short curves
   ecg_pkg::q_type u1_ff, u1_in;
   logic [33:0]    f4_ff, f4_in;
   ecg_pkg::q_type a5_ff, a5_in;
   logic           hi5_ff, hi5_in;
   logic [31:0]    e4_ff, e4_in;
   ecg_pkg::q_type c4_ff, c4_in;
   ecg_pkg::q_type c4d_ff;
   ecg_pkg::q_type sq5_ff, sq5_in;
   logic           hi5d_ff;
   logic [29:0]    sq4_ff, sq4_in;

   // cosine based curves
   ecg_pkg::q_type c16;
   ecg_pkg::q_type a17_ff;
   ecg_pkg::q_type sqa_ff, sqa_in;
   ecg_pkg::q_type cdl_ff [CD];
   ecg_pkg::q_type s31;
   ecg_pkg::q_type pm_ff, pm_in;
   ecg_pkg::q_type m_ff;
   ecg_pkg::q_type mdl_ff [MD];
   ecg_pkg::q_type sq64;
   ecg_pkg::q_type lg56;

   // output register
   logic            rsp_valid_ff;
   ecg_pkg::io_type rsp_value_ff, rsp_value_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   ecg_cos u_cos (
      .clock   (clock),
      .adv     (adv),
      .arg     (u1_ff),
      .cos_val (c16)
   );

   ecg_sqrt u_sqrt_t (
      .clock    (clock),
      .adv      (adv),
      .radicand (val_ff[0]),
      .root     (s31)
   );

   ecg_sqrt u_sqrt_m (
      .clock    (clock),
      .adv      (adv),
      .radicand (m_ff),
      .root     (sq64)
   );

   ecg_logistic u_logistic (
      .clock     (clock),
      .adv       (adv),
      .t_val     (val_ff[0]),
      .curve_val (lg56)
   );

   // front stages: cosine argument, bounce segment, s curve
   always_comb begin
      ecg_pkg::q_type t0;
      ecg_pkg::q_type e3;
      logic [QW:0]    two_t;
      logic [PW-1:0]  mul5;
      logic [63:0]    mul4;
      t0 = val_ff[0];
      e3 = {t0[WB-3:0], 3'b000};
      case (mode_ff[0])
         ecg_pkg::MODE_COS_OUT: u1_in = W - t0;
         ecg_pkg::MODE_RUBBER:  u1_in = (e3 <= W) ? e3 : QW'({W, 1'b0} - {1'b0, e3});
         default:               u1_in = t0;
      endcase
      two_t  = {t0, 1'b0};
      hi5_in = (t0 >= HALF);
      a5_in  = hi5_in ? QW'(two_t - (QW+1)'(W)) : QW'((QW+1)'(W) - two_t);
      f4_in  = 34'({t0, 3'b000}) + 34'({t0, 1'b0}) + 34'(t0);
      if (f4_ff < SEG_A) begin
         e4_in = f4_ff[31:0];
         c4_in = '0;
      end else if (f4_ff < SEG_B) begin
         e4_in = 32'((f4_ff >= MID_A) ? f4_ff - MID_A : MID_A - f4_ff);
         c4_in = LIFT_A;
      end else if (f4_ff < SEG_C) begin
         e4_in = 32'((f4_ff >= MID_B) ? f4_ff - MID_B : MID_B - f4_ff);
         c4_in = LIFT_B;
      end else begin
         e4_in = 32'((f4_ff >= MID_C) ? f4_ff - MID_C : MID_C - f4_ff);
         c4_in = LIFT_C;
      end
      mul5   = PW'(a5_ff) * PW'(a5_ff);
      sq5_in = mul5[WB +: QW];
      mul4   = 64'(e4_ff) * 64'(e4_ff);
      sq4_in = mul4[63:34];
   end

   // squares after the cosine, rubber product
   always_comb begin
      logic [PW-1:0] mula;
      logic [PW-1:0] mulp;
      mula   = PW'(a17_ff) * PW'(a17_ff);
      sqa_in = mula[WB +: QW];
      mulp   = PW'(W - s31) * PW'(cdl_ff[CD-1]);
      pm_in  = mulp[WB +: QW];
   end

   // result chain: each curve drops its value in where it finishes
   always_comb begin
      logic [QW:0]   sum5;
      logic [PW-1:0] mul3;
      val_in[0]  = (req_progress > ecg_pkg::IN_ONE) ?
                   QW'(ecg_pkg::IN_ONE) << (WB - ecg_pkg::FRAC_BITS) :
                   QW'(req_progress) << (WB - ecg_pkg::FRAC_BITS);
      mode_in[0] = csr_mode_ff;
      vld_in[0]  = req_valid;
      for (int k = 1; k <= LAST; k++) begin
         val_in[k]  = val_ff[k-1];
         mode_in[k] = mode_ff[k-1];
         vld_in[k]  = vld_ff[k-1];
      end
      sum5 = hi5d_ff ? (QW+1)'(W) + (QW+1)'(sq5_ff) : (QW+1)'(W - sq5_ff);
      if (mode_ff[2] == ecg_pkg::MODE_SCURVE) begin
         val_in[3] = sum5[QW:1];
      end
      if (mode_ff[3] == ecg_pkg::MODE_BOUNCE) begin
         val_in[4] = QW'(sq4_ff) + c4d_ff;
      end
      if (mode_ff[18] == ecg_pkg::MODE_COS_IN) begin
         val_in[19] = sqa_ff;
      end
      if (mode_ff[18] == ecg_pkg::MODE_COS_OUT) begin
         val_in[19] = W - sqa_ff;
      end
      if (mode_ff[56] == ecg_pkg::MODE_LOGISTIC) begin
         val_in[57] = lg56;
      end
      mul3 = PW'(mdl_ff[MD-1]) * PW'(sq64);
      if (mode_ff[64] == ecg_pkg::MODE_RUBBER) begin
         val_in[65] = mul3[WB +: QW];
      end
   end

   // saturate and round to the output format
   always_comb begin
      ecg_pkg::q_type sat;
      logic [QW:0]    rsum;
      sat          = (val_ff[LAST] > W) ? W : val_ff[LAST];
      rsum         = (QW+1)'(sat) + ROUND_HALF;
      rsp_value_in = ecg_pkg::IN_W'(rsum >> (WB - ecg_pkg::FRAC_BITS));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (csr_wr_en) begin
            csr_mode_ff <= csr_wr_data;
         end
         if (adv) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= vld_ff[LAST];
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         val_ff       <= val_in;
         mode_ff      <= mode_in;
         u1_ff        <= u1_in;
         f4_ff        <= f4_in;
         a5_ff        <= a5_in;
         hi5_ff       <= hi5_in;
         e4_ff        <= e4_in;
         c4_ff        <= c4_in;
         c4d_ff       <= c4_ff;
         sq5_ff       <= sq5_in;
         hi5d_ff      <= hi5_ff;
         sq4_ff       <= sq4_in;
         a17_ff       <= W - c16;
         sqa_ff       <= sqa_in;
         cdl_ff[0]    <= c16;
         for (int i = 1; i < CD; i++) begin
            cdl_ff[i] <= cdl_ff[i-1];
         end
         pm_ff        <= pm_in;
         m_ff         <= W - pm_ff;
         mdl_ff[0]    <= m_ff;
         for (int i = 1; i < MD; i++) begin
            mdl_ff[i] <= mdl_ff[i-1];
         end
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_eased_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_eased_value <= ecg_pkg::IN_ONE)
      else $error("eased value above 1.0");

   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (vld_ff[LAST] == $past(vld_ff[LAST])))
      else $error("pipeline moved while output stalled");

   a_rubber_mid: assert property (@(posedge clock) disable iff (reset)
      vld_ff[33] |-> m_ff <= W)
      else $error("rubber intermediate above 1.0");

   a_cos_arg: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> u1_ff <= W)
      else $error("cosine argument out of range");
`endif

endmodule
